[src/wcld_pkg.sv]
// Package for the word clock LED decoder: payload structs, LED word masks
// and the hour advance minute. Has no dependencies of its own.
`default_nettype none

package wcld_pkg;

  // Face size and the split of the mask into two result fields.
  localparam int LED_COUNT = 114;
  localparam int LOW_SPAN  = 57;

  typedef logic [LED_COUNT-1:0] led_vec_t;

  // One request on the input channel.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } time_t;

  // One request on the output channel.
  typedef struct packed {
    logic [LOW_SPAN-1:0]           leds_low;
    logic [LED_COUNT-LOW_SPAN-1:0] leds_high;
  } face_t;

  // Builds a mask with LEDs first through last (inclusive) lit.
  function automatic led_vec_t span_mask(input int first, input int last);
    led_vec_t m;
    m = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (i >= first && i <= last) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Fixed words.
  localparam led_vec_t MASK_ES_IST  = span_mask(0, 1) | span_mask(3, 5);
  localparam led_vec_t MASK_UHR     = span_mask(99, 101);

  // Minute words.
  localparam led_vec_t MASK_FUENF   = span_mask(7, 10);
  localparam led_vec_t MASK_ZWANZIG = span_mask(11, 17);
  localparam led_vec_t MASK_ZEHN    = span_mask(18, 21);
  localparam led_vec_t MASK_VIERTEL = span_mask(26, 32);
  localparam led_vec_t MASK_NACH    = span_mask(33, 36);
  localparam led_vec_t MASK_VOR     = span_mask(41, 43);
  localparam led_vec_t MASK_HALB    = span_mask(44, 47);

  // Hour words.
  localparam led_vec_t MASK_H_EIN    = span_mask(63, 65);
  localparam led_vec_t MASK_H_EINS_S = span_mask(62, 62);
  localparam led_vec_t MASK_H_ZWEI   = span_mask(55, 58);
  localparam led_vec_t MASK_H_DREI   = span_mask(66, 69);
  localparam led_vec_t MASK_H_VIER   = span_mask(73, 76);
  localparam led_vec_t MASK_H_FUENF  = span_mask(51, 54);
  localparam led_vec_t MASK_H_SECHS  = span_mask(83, 87);
  localparam led_vec_t MASK_H_SIEBEN = span_mask(88, 93);
  localparam led_vec_t MASK_H_ACHT   = span_mask(77, 80);
  localparam led_vec_t MASK_H_NEUN   = span_mask(103, 106);
  localparam led_vec_t MASK_H_ZEHN   = span_mask(106, 109);
  localparam led_vec_t MASK_H_ELF    = span_mask(49, 51);
  localparam led_vec_t MASK_H_ZWOELF = span_mask(94, 98);

  // Corner dots, first one at this LED.
  localparam int DOT_BASE = 110;

  // Minute at which the spoken hour moves to the next one.
  localparam logic [5:0] HOUR_ADVANCE_MIN = 6'd25;

endpackage

`default_nettype wire

[src/word_clock_led_decoder.sv]
// Word clock LED decoder: 114-LED mask of a German word clock face from the
// hour and minute. Requests pass the input register and the result register;
// throughput is one request per cycle while the output side does not stall.
// The input register feeds a short decode into the result register; either
// stage holds its request while the side after it stalls.
// Reset (rst, synchronous) empties both stages; payload registers keep data.
// Depends on wcld_pkg.
`default_nettype none

module word_clock_led_decoder
  import wcld_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire time_t in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output face_t      out_data
);

  // Input register.
  logic  s1_valid;
  time_t s1_data;

  // Handshake: each stage moves when the one after it can take a request.
  logic out_ready;
  logic s1_ready;

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Minute slot (minute / 5) by reciprocal multiply, exact for 0..63.
  logic [9:0] min_prod;
  logic [3:0] slot;
  logic [6:0] slot_x5;
  logic [2:0] dots;

  assign min_prod = 10'(s1_data.minute) * 10'd13;
  assign slot     = min_prod[9:6];
  assign slot_x5  = 7'({slot, 2'b00}) + 7'(slot);
  assign dots     = 3'(7'(s1_data.minute) - slot_x5);

  // Hour of the twelve-hour dial, zero shown as twelve, advanced from :25 on.
  logic [4:0] hour_m24;
  logic [3:0] hour_m12;
  logic [3:0] hour_dial;
  logic [3:0] hour_word;

  always_comb begin
    hour_m24 = (s1_data.hour >= 5'd24) ? s1_data.hour - 5'd24 : s1_data.hour;
    hour_m12 = (hour_m24 >= 5'd12) ? 4'(hour_m24 - 5'd12) : hour_m24[3:0];
    hour_dial = (hour_m12 == 4'd0) ? 4'd12 : hour_m12;
    if (s1_data.minute >= HOUR_ADVANCE_MIN) begin
      hour_word = (hour_dial == 4'd12) ? 4'd1 : hour_dial + 4'd1;
    end else begin
      hour_word = hour_dial;
    end
  end

  // Face mask: fixed words, minute words, hour word and corner dots.
  led_vec_t face;

  always_comb begin
    face = MASK_ES_IST;

    unique case (slot)
      4'd0:  face = face | MASK_UHR;
      4'd1:  face = face | MASK_FUENF | MASK_NACH;
      4'd2:  face = face | MASK_ZEHN | MASK_NACH;
      4'd3:  face = face | MASK_VIERTEL | MASK_NACH;
      4'd4:  face = face | MASK_ZWANZIG | MASK_NACH;
      4'd5:  face = face | MASK_FUENF | MASK_VOR | MASK_HALB;
      4'd6:  face = face | MASK_HALB;
      4'd7:  face = face | MASK_FUENF | MASK_NACH | MASK_HALB;
      4'd8:  face = face | MASK_ZWANZIG | MASK_VOR;
      4'd9:  face = face | MASK_VIERTEL | MASK_VOR;
      4'd10: face = face | MASK_ZEHN | MASK_VOR;
      4'd11: face = face | MASK_FUENF | MASK_VOR;
      // Minutes 60 to 63 light no minute words.
      default: face = face;
    endcase

    unique case (hour_word)
      4'd1: begin
        face = face | MASK_H_EIN;
        // The S of EINS shows from minute 5 on, so the top of the hour reads EIN UHR.
        if (s1_data.minute >= 6'd5) begin
          face = face | MASK_H_EINS_S;
        end
      end
      4'd2:  face = face | MASK_H_ZWEI;
      4'd3:  face = face | MASK_H_DREI;
      4'd4:  face = face | MASK_H_VIER;
      4'd5:  face = face | MASK_H_FUENF;
      4'd6:  face = face | MASK_H_SECHS;
      4'd7:  face = face | MASK_H_SIEBEN;
      4'd8:  face = face | MASK_H_ACHT;
      4'd9:  face = face | MASK_H_NEUN;
      4'd10: face = face | MASK_H_ZEHN;
      4'd11: face = face | MASK_H_ELF;
      default: face = face | MASK_H_ZWOELF;
    endcase

    unique case (dots)
      3'd1: face = face | span_mask(DOT_BASE, DOT_BASE);
      3'd2: face = face | span_mask(DOT_BASE, DOT_BASE + 1);
      3'd3: face = face | span_mask(DOT_BASE, DOT_BASE + 2);
      3'd4: face = face | span_mask(DOT_BASE, DOT_BASE + 3);
      default: face = face;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      out_data.leds_low  <= face[LOW_SPAN-1:0];
      out_data.leds_high <= face[LED_COUNT-1:LOW_SPAN];
    end
  end

`ifndef SYNTHESIS
  // A request in the input register waits while the result is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> (s1_valid && $stable(s1_data)))
    else $error("input stage lost its request while the output stalled");

  // The input side is stalled only when both stages are full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // ES IST is lit on every result.
  a_es_ist: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.leds_low[5:0] & 6'b111011) == 6'b111011))
    else $error("ES IST missing from the face");

  // Corner dots fill in order from the first one.
  a_dots_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!out_data.leds_high[56] || out_data.leds_high[55]) &&
                   (!out_data.leds_high[55] || out_data.leds_high[54]) &&
                   (!out_data.leds_high[54] || out_data.leds_high[53])))
    else $error("corner dots out of order");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for word_clock_led_decoder: directed times, then
// random times under three idling patterns, each face checked against a typed or predicted face.
// Depends on wcld_pkg and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
  import wcld_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_TIMES  = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 25;

  // One directed row: whether the face is typed in, the time, and that face.
  typedef struct packed {
    logic                          typed;
    logic [4:0]                    hour;
    logic [5:0]                    minute;
    logic [LOW_SPAN-1:0]           leds_low;
    logic [LED_COUNT-LOW_SPAN-1:0] leds_high;
  } time_row_t;

  // Midnight and the all-ones corner are typed in; the rest go through the predictor.
  localparam time_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    {1'b1, 5'd0,  6'd0,  57'h3B, 57'h1FE000000000},
    {1'b1, 5'd31, 6'd63, 57'h3B, 57'h00E0_0000_00F0_0000},
    {1'b0, 5'd12, 6'd0,  57'd0, 57'd0},
    {1'b0, 5'd1,  6'd0,  57'd0, 57'd0},
    {1'b0, 5'd1,  6'd4,  57'd0, 57'd0},
    {1'b0, 5'd1,  6'd5,  57'd0, 57'd0},
    {1'b0, 5'd0,  6'd25, 57'd0, 57'd0},
    {1'b0, 5'd12, 6'd24, 57'd0, 57'd0},
    {1'b0, 5'd2,  6'd10, 57'd0, 57'd0},
    {1'b0, 5'd3,  6'd15, 57'd0, 57'd0},
    {1'b0, 5'd4,  6'd20, 57'd0, 57'd0},
    {1'b0, 5'd5,  6'd30, 57'd0, 57'd0},
    {1'b0, 5'd6,  6'd35, 57'd0, 57'd0},
    {1'b0, 5'd7,  6'd40, 57'd0, 57'd0},
    {1'b0, 5'd8,  6'd45, 57'd0, 57'd0},
    {1'b0, 5'd9,  6'd50, 57'd0, 57'd0},
    {1'b0, 5'd10, 6'd55, 57'd0, 57'd0},
    {1'b0, 5'd11, 6'd59, 57'd0, 57'd0},
    {1'b0, 5'd23, 6'd59, 57'd0, 57'd0},
    {1'b0, 5'd24, 6'd60, 57'd0, 57'd0},
    {1'b0, 5'd30, 6'd61, 57'd0, 57'd0},
    {1'b0, 5'd28, 6'd62, 57'd0, 57'd0},
    {1'b0, 5'd17, 6'd3,  57'd0, 57'd0},
    {1'b0, 5'd21, 6'd27, 57'd0, 57'd0},
    {1'b0, 5'd0,  6'd1,  57'd0, 57'd0}
  };

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  time_t in_data   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  face_t out_data;

  face_t pending_faces[$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;

  word_clock_led_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk = ~clk;
    end
  end

  // Lights LEDs lo through hi of the face.
  function automatic led_vec_t word_lit(input int lo, input int hi);
    led_vec_t ones;
    ones = '1;
    return (ones >> (LED_COUNT - 1 - (hi - lo))) << lo;
  endfunction

  // Works out the face that a given time should light.
  function automatic face_t predict_face(input time_t t);
    led_vec_t lit;
    int       dots;
    int       spoken;
    face_t    face;
    lit  = word_lit(0, 1) | word_lit(3, 5);
    dots = t.minute % 5;
    for (int i = 0; i < dots; i++) begin
      lit[DOT_BASE + i] = 1'b1;
    end

    // Minute words; minutes 60 and up light none.
    case (t.minute / 5)
      0:  lit |= word_lit(99, 101);
      1:  lit |= word_lit(7, 10) | word_lit(33, 36);
      2:  lit |= word_lit(18, 21) | word_lit(33, 36);
      3:  lit |= word_lit(26, 32) | word_lit(33, 36);
      4:  lit |= word_lit(11, 17) | word_lit(33, 36);
      5:  lit |= word_lit(7, 10) | word_lit(41, 43) | word_lit(44, 47);
      6:  lit |= word_lit(44, 47);
      7:  lit |= word_lit(7, 10) | word_lit(33, 36) | word_lit(44, 47);
      8:  lit |= word_lit(11, 17) | word_lit(41, 43);
      9:  lit |= word_lit(26, 32) | word_lit(41, 43);
      10: lit |= word_lit(18, 21) | word_lit(41, 43);
      11: lit |= word_lit(7, 10) | word_lit(41, 43);
      default: ;
    endcase

    // Spoken hour: twelve for zero, one hour on from the advance minute.
    spoken = t.hour % 12;
    if (spoken == 0) begin
      spoken = 12;
    end
    if (t.minute >= HOUR_ADVANCE_MIN) begin
      spoken = (spoken == 12) ? 1 : spoken + 1;
    end
    case (spoken)
      1: begin
        lit |= word_lit(63, 65);
        if (t.minute >= 5) begin
          lit[62] = 1'b1;
        end
      end
      2:  lit |= word_lit(55, 58);
      3:  lit |= word_lit(66, 69);
      4:  lit |= word_lit(73, 76);
      5:  lit |= word_lit(51, 54);
      6:  lit |= word_lit(83, 87);
      7:  lit |= word_lit(88, 93);
      8:  lit |= word_lit(77, 80);
      9:  lit |= word_lit(103, 106);
      10: lit |= word_lit(106, 109);
      11: lit |= word_lit(49, 51);
      default: lit |= word_lit(94, 98);
    endcase

    face.leds_low  = lit[LOW_SPAN-1:0];
    face.leds_high = lit[LED_COUNT-1:LOW_SPAN];
    return face;
  endfunction

  // Offers one time after a random gap and records its face once accepted.
  task automatic send_time(input time_t t, input face_t face);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_faces.push_back(face);
  endtask

  // Checks each delivered face and draws the next stall.
  always @(posedge clk) begin : face_check
    face_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_faces.size() == 0) begin
        $display("%0t: unexpected face leds_low %h leds_high %h",
                 $time, out_data.leds_low, out_data.leds_high);
        mismatch_count++;
      end else begin
        want = pending_faces.pop_front();
        if (out_data.leds_low !== want.leds_low) begin
          $display("%0t: leds_low expected %h actual %h",
                   $time, want.leds_low, out_data.leds_low);
          mismatch_count++;
        end
        if (out_data.leds_high !== want.leds_high) begin
          $display("%0t: leds_high expected %h actual %h",
                   $time, want.leds_high, out_data.leds_high);
          mismatch_count++;
        end
      end
    end
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  // Ends a run that hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, directed rows, three random phases, then drain.
  initial begin : stimulus
    time_t t;
    face_t face;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 16;
    recv_stall_pct = 52;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      t.hour   = DIRECTED[r].hour;
      t.minute = DIRECTED[r].minute;
      if (DIRECTED[r].typed) begin
        face.leds_low  = DIRECTED[r].leds_low;
        face.leds_high = DIRECTED[r].leds_high;
      end else begin
        face = predict_face(t);
      end
      send_time(t, face);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 16;
          recv_stall_pct = 52;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 16;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_TIMES / 3; n++) begin
        // Mostly real clock times, now and then any bit pattern.
        if ($urandom_range(9) == 0) begin
          t.hour   = 5'($urandom_range(31));
          t.minute = 6'($urandom_range(63));
        end else begin
          t.hour   = 5'($urandom_range(23));
          t.minute = 6'($urandom_range(59));
        end
        send_time(t, predict_face(t));
      end
    end
    in_valid <= 1'b0;

    while (pending_faces.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
